// ===== design/mer_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // byte codes seen or produced by the repair
  localparam logic [7:0] ByteEf   = 8'hEF;
  localparam logic [7:0] ByteBf   = 8'hBF;
  localparam logic [7:0] ByteBd   = 8'hBD;
  localparam logic [7:0] ByteFf   = 8'hFF;
  localparam logic [7:0] ByteFd   = 8'hFD;
  localparam logic [7:0] ByteCr   = 8'h0D;
  localparam logic [7:0] ByteLf   = 8'h0A;
  localparam logic [7:0] ByteZero = 8'h00;

  // byte order mark dropped as the first unit of a stream
  localparam logic [15:0] UnitBom = 16'hFEFF;

  // most bytes one input word can release, and the queue geometry
  localparam int unsigned GrpBytes = 4;
  localparam int unsigned GrpCntW  = 3;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QDepth   = 1 << QPtrW;

  // prefix held by the front while a match is still open
  typedef enum logic [1:0] {
    LA_NONE,
    LA_CR,
    LA_EF,
    LA_EFBF
  } la_e;

  // repaired bytes released by one input word
  typedef struct packed {
    logic [GrpBytes-1:0][7:0] bytes;
    logic [GrpCntW-1:0]       cnt;
    logic                     last;
  } grp_t;

  // one result word
  typedef struct packed {
    logic [15:0] unit;
    logic        valid;
    logic        eos;
  } res_t;

endpackage

`default_nettype wire

// ===== design/mer_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          last_byte_i,
  output logic          push_o,
  output mer_pkg::grp_t grp_o
);
  import mer_pkg::*;

  la_e  la_q, la_d;
  grp_t g;
  logic do_start;

  // match resolution: bytes released by this word and the prefix left open
  always_comb begin
    g        = '0;
    la_d     = la_q;
    do_start = 1'b0;
    g.last   = last_byte_i;
    case (la_q)
      LA_NONE: begin
        do_start = 1'b1;
      end
      LA_CR: begin
        la_d = LA_NONE;
        if (in_byte_i == ByteLf) begin
          g.bytes[0] = ByteZero;
          g.bytes[1] = ByteCr;
          g.bytes[2] = ByteZero;
          g.bytes[3] = ByteLf;
          g.cnt      = GrpCntW'(4);
        end else begin
          g.bytes[0] = ByteCr;
          g.cnt      = GrpCntW'(1);
          do_start   = 1'b1;
        end
      end
      LA_EF: begin
        if (in_byte_i == ByteBf) begin
          la_d = LA_EFBF;
        end else begin
          la_d       = LA_NONE;
          g.bytes[0] = ByteEf;
          g.cnt      = GrpCntW'(1);
          do_start   = 1'b1;
        end
      end
      LA_EFBF: begin
        la_d = LA_NONE;
        if (in_byte_i == ByteBd) begin
          g.bytes[0] = ByteFf;
          g.bytes[1] = ByteFd;
          g.cnt      = GrpCntW'(2);
        end else begin
          g.bytes[0] = ByteEf;
          g.bytes[1] = ByteBf;
          g.cnt      = GrpCntW'(2);
          do_start   = 1'b1;
        end
      end
      default: begin
        la_d     = LA_NONE;
        do_start = 1'b1;
      end
    endcase

    // fresh look at the new byte
    if (do_start) begin
      if (in_byte_i == ByteEf) begin
        la_d = LA_EF;
      end else if (in_byte_i == ByteCr) begin
        la_d = LA_CR;
      end else begin
        la_d                  = LA_NONE;
        g.bytes[g.cnt[1:0]]   = in_byte_i;
        g.cnt                 = g.cnt + GrpCntW'(1);
      end
    end

    // end of stream: open prefix goes out raw
    if (last_byte_i) begin
      case (la_d)
        LA_CR: begin
          g.bytes[g.cnt[1:0]] = ByteCr;
          g.cnt               = g.cnt + GrpCntW'(1);
        end
        LA_EF: begin
          g.bytes[g.cnt[1:0]] = ByteEf;
          g.cnt               = g.cnt + GrpCntW'(1);
        end
        LA_EFBF: begin
          g.bytes[g.cnt[1:0]] = ByteEf;
          g.cnt               = g.cnt + GrpCntW'(1);
          g.bytes[g.cnt[1:0]] = ByteBf;
          g.cnt               = g.cnt + GrpCntW'(1);
        end
        default: begin
        end
      endcase
      la_d = LA_NONE;
    end
  end

  // words that release nothing and do not end the stream stay out of the queue
  assign grp_o  = g;
  assign push_o = accept_i && ((g.cnt != '0) || last_byte_i);

  // prefix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q <= LA_NONE;
    end else if (accept_i) begin
      la_q <= la_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mer_pkg::grp_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output mer_pkg::grp_t head_o
);
  import mer_pkg::*;

  grp_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o       = (cnt_q == (QPtrW+1)'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/mer_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  mer_pkg::grp_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   code_unit_o,
  output logic          unit_valid_o,
  output logic          end_of_stream_o
);
  import mer_pkg::*;

  logic       held_q, held_d;
  logic [7:0] half_q, half_d;
  logic       first_q, first_d;
  logic       sub_q, sub_d;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;
  res_t       res [2];
  logic [1:0] r_cnt;
  logic       slot_free;
  logic       load;

  // pairing of held byte and released bytes into results
  always_comb begin
    logic [7:0]         s [5];
    logic [GrpCntW-1:0] m;
    logic [1:0]         nu;
    logic [15:0]        u0, u1;
    logic               drop;
    s[0] = held_q ? half_q         : head_i.bytes[0];
    s[1] = held_q ? head_i.bytes[0] : head_i.bytes[1];
    s[2] = held_q ? head_i.bytes[1] : head_i.bytes[2];
    s[3] = held_q ? head_i.bytes[2] : head_i.bytes[3];
    s[4] = held_q ? head_i.bytes[3] : 8'h00;
    m    = GrpCntW'(held_q) + head_i.cnt;
    nu   = m[2:1];
    u0   = {s[0], s[1]};
    u1   = {s[2], s[3]};
    drop = first_q && (nu != 2'd0) && (u0 == UnitBom);

    res[0] = '0;
    res[1] = '0;
    r_cnt  = 2'd0;
    if (drop) begin
      if (nu == 2'd2) begin
        res[0] = '{unit: u1, valid: 1'b1, eos: 1'b0};
        r_cnt  = 2'd1;
      end
    end else begin
      res[0] = '{unit: u0, valid: 1'b1, eos: 1'b0};
      res[1] = '{unit: u1, valid: 1'b1, eos: 1'b0};
      r_cnt  = nu;
    end
    if (head_i.last) begin
      if (r_cnt == 2'd0) begin
        res[0] = '{unit: 16'h0000, valid: 1'b0, eos: 1'b1};
        r_cnt  = 2'd1;
      end else if (r_cnt == 2'd1) begin
        res[0].eos = 1'b1;
      end else begin
        res[1].eos = 1'b1;
      end
    end

    // state left for the next word
    case (m)
      GrpCntW'(3): half_d = s[2];
      GrpCntW'(5): half_d = s[4];
      default:     half_d = s[0];
    endcase
    held_d  = head_i.last ? 1'b0 : m[0];
    first_d = head_i.last ? 1'b1 : ((nu != 2'd0) ? 1'b0 : first_q);
  end

  // result issue, one per cycle through the output register while the output is not stalled
  always_comb begin
    slot_free   = !out_valid_q || out_ready_i;
    load        = 1'b0;
    pop_o       = 1'b0;
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    if (slot_free) begin
      out_valid_d = 1'b0;
      if (head_valid_i) begin
        if (r_cnt == 2'd0) begin
          pop_o = 1'b1;
        end else begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          if ({1'b0, sub_q} == (r_cnt - 2'd1)) begin
            pop_o = 1'b1;
            sub_d = 1'b0;
          end else begin
            sub_d = 1'b1;
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      first_q     <= 1'b1;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        held_q  <= held_d;
        first_q <= first_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      half_q <= half_d;
    end
    if (load) begin
      out_q <= res[sub_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_unit_o     = out_q.unit;
  assign unit_valid_o    = out_q.valid;
  assign end_of_stream_o = out_q.eos;

  // second result of a word only while that word still heads the queue
  a_sub_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (head_valid_i && r_cnt == 2'd2))
    else $error("second result pending without a two-result word");

  // a bare end marker always closes the stream
  a_bare_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.valid) |-> out_q.eos)
    else $error("bare marker without end of stream");

  // stream end restores pairing state
  a_eos_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |=> (!held_q && first_q))
    else $error("pairing state not restored after end of stream");

  // every end of stream word taken from the queue loads a result
  a_pop_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |-> load)
    else $error("end of stream word popped without a result");

endmodule

`default_nettype wire

// ===== design/mixed_encoding_repair_utf16be.sv =====
// channel   direction  handshake                 payload
// input     in         in_valid_i / in_ready_o   in_byte_i[7:0], last_byte_i
// output    out        out_valid_o / out_ready_i code_unit_o[15:0], unit_valid_o,
//                                                end_of_stream_o
//
// one byte accepted per cycle while the four-entry queue has room
// results leave one per cycle from the output register while the output is not stalled; a byte that releases
// two code units holds the queue head until both have been issued
// first result of a byte is registered in the queue and then in the output register
// reset empties the queue, clears the match prefix and arms byte order mark removal
// a stalled output holds its word; input ready falls only when the queue is full
`timescale 1ns / 1ps
`default_nettype none

module mixed_encoding_repair_utf16be (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        unit_valid_o,
  output logic        end_of_stream_o
);
  import mer_pkg::*;

  logic accept;
  logic push;
  grp_t grp;
  logic q_full;
  logic pop;
  logic head_valid;
  grp_t head;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // front: prefix matching
  mer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .grp_o       (grp)
  );

  // queue between front and back
  mer_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_i       (grp),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: pairing into code units and result issue
  mer_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_unit_o     (code_unit_o),
    .unit_valid_o    (unit_valid_o),
    .end_of_stream_o (end_of_stream_o)
  );

endmodule

`default_nettype wire
